>>> sv/od_cube27_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// od_cube27_pkg: shared constants and functions
// Bayer 16x16 threshold lookup and the 3-level quantizer used by the
// ordered-dither cube27 block.
// ----------------------------------------------------------------------------
package od_cube27_pkg;

    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned PHASE_W   = 4;
    localparam int unsigned THR_W     = 8;   // matrix value before the 256 scale
    localparam int unsigned LEVEL_W   = 2;
    localparam int unsigned INDEX_W   = 5;
    localparam int unsigned LEVEL_MAX = 2;
    localparam int unsigned LEVELS    = LEVEL_MAX + 1;
    localparam int unsigned LEVEL_MUL = 256 * LEVEL_MAX + LEVEL_MAX + 1;  // 515
    localparam int unsigned SUM_W     = 18;

    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [PHASE_W-1:0] phase_t;
    typedef logic [THR_W-1:0]   thr_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [INDEX_W-1:0] index_t;

    // Quadrant digit, indexed by {row bit, column bit}.
    function automatic logic [1:0] quad_digit(input logic rb, input logic cb);
        logic [1:0] d;
        case ({rb, cb})
            2'b00:   d = 2'd0;
            2'b01:   d = 2'd3;
            2'b10:   d = 2'd2;
            2'b11:   d = 2'd1;
            default: d = 2'd0;
        endcase
        return d;
    endfunction

    // Bit 0 of the phases gives the most significant base-4 digit.
    function automatic thr_t bayer_thr(input phase_t row, input phase_t col);
        thr_t v;
        v = '0;
        for (int k = 0; k < PHASE_W; k++)
        begin
            v = {v[THR_W-3:0], quad_digit(row[2'(k)], col[2'(k)])};
        end
        return v;
    endfunction

    // (515*c + 256*v) >> 16, always 0..2.
    function automatic level_t quantize(input chan_t c, input thr_t v);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(c) * SUM_W'(LEVEL_MUL) + SUM_W'({v, 8'h00});
        return sum[SUM_W-1:SUM_W-LEVEL_W];
    endfunction

endpackage

>>> sv/od_cube27_pix_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// od_cube27_pix_if: pixel channel
// Valid/ready channel carrying one RGB pixel with line and frame end marks.
// ----------------------------------------------------------------------------
interface od_cube27_pix_if
    import od_cube27_pkg::*;
();
    logic  valid;
    logic  ready;
    chan_t pixel_red;
    chan_t pixel_green;
    chan_t pixel_blue;
    logic  line_end;
    logic  frame_end;

    modport source (output valid, pixel_red, pixel_green, pixel_blue, line_end, frame_end,
                    input ready);
    modport sink   (input valid, pixel_red, pixel_green, pixel_blue, line_end, frame_end,
                    output ready);
endinterface

>>> sv/od_cube27_idx_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// od_cube27_idx_if: palette index channel
// Valid/ready channel carrying one 5-bit cube palette index.
// ----------------------------------------------------------------------------
interface od_cube27_idx_if
    import od_cube27_pkg::*;
();
    logic   valid;
    logic   ready;
    index_t palette_index;

    modport source (output valid, palette_index, input ready);
    modport sink   (input valid, palette_index, output ready);
endinterface

>>> sv/ordered_dither_rgb_to_cube27_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_dither_rgb_to_cube27_top: Bayer 16x16 ordered dither to 27 colors
// Path: stage 1 captures the pixel, then stage 2 registers its index for idx.
// Throughput: 1 pixel per cycle unless idx.ready stalls it, set by the
// two-stage input/result pipeline. Backpressure stalls both stages; a new
// pixel is taken whenever stage 1 is empty or moves on in the same cycle.
// Reset (rst_n, async low) clears both phases and all stage valid flags.
// ----------------------------------------------------------------------------
module ordered_dither_rgb_to_cube27_top
    import od_cube27_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    od_cube27_pix_if.sink   pix,
    od_cube27_idx_if.source idx
);

    // Raster position of the next pixel, modulo 16.
    phase_t col_phase_reg, col_phase_next;
    phase_t row_phase_reg, row_phase_next;

    // Stage 1: captured pixel plus its matrix threshold.
    logic   s1_valid_reg;
    chan_t  s1_red_reg, s1_green_reg, s1_blue_reg;
    thr_t   s1_thr_reg;

    // Stage 2: result register.
    logic   s2_valid_reg;
    index_t s2_index_reg, s2_index_next;

    logic   s2_adv;
    logic   s1_adv;
    logic   pix_take;
    level_t lvl_r, lvl_g, lvl_b;

    // Stage 2 can load when empty or its index is taken this cycle.
    assign s2_adv   = !s2_valid_reg || idx.ready;
    // Stage 1 can load when empty or its content moves to stage 2.
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign pix.ready = s1_adv;
    assign pix_take  = pix.valid && s1_adv;

    // Phase update: frame end wins over line end.
    always_comb
    begin
        col_phase_next = col_phase_reg;
        row_phase_next = row_phase_reg;
        if (pix_take)
        begin
            if (pix.frame_end)
            begin
                col_phase_next = '0;
                row_phase_next = '0;
            end
            else if (pix.line_end)
            begin
                col_phase_next = '0;
                row_phase_next = row_phase_reg + phase_t'(1);
            end
            else
            begin
                col_phase_next = col_phase_reg + phase_t'(1);
            end
        end
    end

    // Quantize each channel and pack red-major.
    always_comb
    begin
        lvl_r = quantize(s1_red_reg,   s1_thr_reg);
        lvl_g = quantize(s1_green_reg, s1_thr_reg);
        lvl_b = quantize(s1_blue_reg,  s1_thr_reg);
        s2_index_next = INDEX_W'(lvl_r) * INDEX_W'(LEVELS * LEVELS)
                      + INDEX_W'(lvl_g) * INDEX_W'(LEVELS)
                      + INDEX_W'(lvl_b);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_phase_reg <= '0;
            row_phase_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            col_phase_reg <= col_phase_next;
            row_phase_reg <= row_phase_next;
            if (s1_adv)
            begin
                s1_valid_reg <= pix.valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (pix_take)
        begin
            s1_red_reg   <= pix.pixel_red;
            s1_green_reg <= pix.pixel_green;
            s1_blue_reg  <= pix.pixel_blue;
            s1_thr_reg   <= bayer_thr(row_phase_reg, col_phase_reg);
        end
        if (s2_adv && s1_valid_reg)
        begin
            s2_index_reg <= s2_index_next;
        end
    end

    assign idx.valid         = s2_valid_reg;
    assign idx.palette_index = s2_index_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx.valid |-> (idx.palette_index <= index_t'(LEVELS * LEVELS * LEVELS - 1)))
        else $error("palette index out of cube range");

    a_frame_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_take && pix.frame_end) |=> (col_phase_reg == '0 && row_phase_reg == '0))
        else $error("phases not cleared after frame end");

    a_line_step: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_take && pix.line_end && !pix.frame_end) |=>
            (col_phase_reg == '0 && row_phase_reg == $past(row_phase_reg) + phase_t'(1)))
        else $error("row phase did not advance at line end");

    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_take && !pix.line_end && !pix.frame_end) |=>
            (col_phase_reg == $past(col_phase_reg) + phase_t'(1)
             && row_phase_reg == $past(row_phase_reg)))
        else $error("column phase did not advance");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_take |=> (col_phase_reg == $past(col_phase_reg)
                       && row_phase_reg == $past(row_phase_reg)))
        else $error("phases changed without a pixel transaction");

endmodule
